// File: src/bmg_pkg.sv
package bmg_pkg;

  localparam int FieldW   = 13;
  localparam int CutW     = 16;
  localparam int OrdW     = 5;
  localparam int RespW    = 17;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  localparam int DefMaxSize  = 4096;
  localparam int DefMaxOrder = 16;

  localparam logic [FieldW-1:0] RstWidth  = 13'd256;
  localparam logic [FieldW-1:0] RstHeight = 13'd256;
  localparam logic [CutW-1:0]   RstCutoff = 16'd8192;
  localparam logic [OrdW-1:0]   RstOrder  = 5'd2;

  // Q.32 power values, flushed at 2^49
  localparam int FracW    = 32;
  localparam int PowW     = 49;
  localparam int PreShift = 60 - PowW;

  localparam int AW   = FieldW + 1;          // half-pixel distance
  localparam int SW   = 2 * AW + 1;          // squared distance sum
  localparam int KW   = CutW + FieldW;       // cutoff * (width-1)
  localparam int KKW  = 2 * KW;
  localparam int RemW = KKW + 1;
  localparam int DenW = PowW + 1;
  localparam int QW   = RespW;
  localparam int RDivW = DenW + QW - 1;

  localparam int PpW = 2 * (PowW - FracW);   // high x high partial

  typedef enum logic [CfgAddrW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_CUTOFF = 2'd2,
    REG_ORDER  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic            v;
    logic            z;
    logic            ovf;
    logic [PowW-1:0] acc;
    logic [PowW-1:0] base;
  } pw_t;

endpackage

// File: src/butterworth_mask_generator_top.sv
// Butterworth low-pass mask generator: one (row, column) item in, one Q1.16 gain out,
// 1/(1+(d/D)^(2n)) with 65536 meaning 1.0. The pipeline takes a new item every cycle
// while the skid register is empty. Its register stages are the two front stages, the
// 50-stage ratio divider, the two-stage multipliers of each power step, the 18-stage
// reciprocal divider and the output register. A skid register at the output absorbs
// one stall; in_tready drops only while it is full.
// Write the configuration registers only while no item is in flight.
module butterworth_mask_generator_top #(
  parameter int MAX_SIZE  = bmg_pkg::DefMaxSize,
  parameter int MAX_ORDER = bmg_pkg::DefMaxOrder
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // row[12:0], column[25:13]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // response[16:0]
  input  logic                           cfg_wr_en,
  input  logic [bmg_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [bmg_pkg::CfgDataW-1:0]   cfg_wdata
);

  localparam int FW    = bmg_pkg::FieldW;
  localparam int AW    = bmg_pkg::AW;
  localparam int SW    = bmg_pkg::SW;
  localparam int KW    = bmg_pkg::KW;
  localparam int KKW   = bmg_pkg::KKW;
  localparam int RemW  = bmg_pkg::RemW;
  localparam int PowW  = bmg_pkg::PowW;
  localparam int DenW  = bmg_pkg::DenW;
  localparam int QW    = bmg_pkg::QW;
  localparam int RDivW = bmg_pkg::RDivW;
  localparam int OrdW  = bmg_pkg::OrdW;
  localparam int OBits = $clog2(MAX_ORDER + 1);
  localparam int PSteps = (OBits > OrdW) ? OrdW : OBits;

  // ---------------- configuration ----------------
  logic [FW-1:0]             width_r, height_r;
  logic [bmg_pkg::CutW-1:0]  cutoff_r;
  logic [OrdW-1:0]           order_r;
  logic [FW-1:0]             cfg_sz;
  logic [OrdW-1:0]           cfg_ord;

  assign cfg_sz  = ({19'd0, cfg_wdata[FW-1:0]} > 32'(MAX_SIZE)) ? FW'(MAX_SIZE)
                                                                : cfg_wdata[FW-1:0];
  assign cfg_ord = ({27'd0, cfg_wdata[OrdW-1:0]} > 32'(MAX_ORDER)) ? OrdW'(MAX_ORDER)
                                                                   : cfg_wdata[OrdW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bmg_pkg::RstWidth;
      height_r <= bmg_pkg::RstHeight;
      cutoff_r <= bmg_pkg::RstCutoff;
      order_r  <= bmg_pkg::RstOrder;
    end else if (cfg_wr_en) begin
      unique case (bmg_pkg::cfg_reg_t'(cfg_addr))
        bmg_pkg::REG_WIDTH:  width_r  <= cfg_sz;
        bmg_pkg::REG_HEIGHT: height_r <= cfg_sz;
        bmg_pkg::REG_CUTOFF: cutoff_r <= cfg_wdata;
        bmg_pkg::REG_ORDER:  order_r  <= cfg_ord;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic skid_v_r, out_v_r;
  logic en;
  assign en        = ~skid_v_r;
  assign in_tready = en;

  // ---------------- stage 1: fold ----------------
  logic [FW-1:0] row, col;
  logic          even_w;
  logic [AW-1:0] xh, yh, x, y, zrow, low;
  logic          z1_nxt;
  assign row    = in_tdata[FW-1:0];
  assign col    = in_tdata[2*FW-1:FW];
  assign even_w = ~width_r[0];
  assign low    = even_w ? AW'(1) : AW'(2);
  assign xh     = ({1'b0, width_r} + AW'(1)) >> 1;
  assign yh     = ({1'b0, height_r} + AW'(1)) >> 1;
  assign x      = ({1'b0, col} <= xh) ? {1'b0, col} : {1'b0, width_r} + low - {1'b0, col};
  assign y      = ({1'b0, row} <= yh) ? {1'b0, row} : {1'b0, height_r} + low - {1'b0, row};
  assign zrow   = height_r[0] ? yh : AW'(height_r >> 1) + AW'(1);
  assign z1_nxt = (row == '0) || (row > height_r) || (col == '0) || (col > width_r)
               || ((width_r[0] ^ height_r[0]) && ({1'b0, row} == zrow));

  logic          v1_r, z1_r;
  logic [AW-1:0] a1_r, b1_r;
  logic [KW-1:0] k1_r;
  logic [FW-1:0] wm1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_tvalid;
      z1_r  <= z1_nxt;
      a1_r  <= ((x - AW'(1)) << 1) + AW'(even_w);
      b1_r  <= ((y - AW'(1)) << 1) + AW'(even_w);
      k1_r  <= cutoff_r * (width_r - FW'(1));
      wm1_r <= width_r - FW'(1);
    end
  end

  // ---------------- stage 2: squares ----------------
  logic            v2_r, z2_r, kz2_r;
  logic [2*AW-1:0] aa2_r, bb2_r;
  logic [KKW-1:0]  kk2_r;
  logic [2*FW-1:0] wsq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r   <= v1_r;
      z2_r   <= z1_r;
      kz2_r  <= (k1_r == '0);
      aa2_r  <= a1_r * a1_r;
      bb2_r  <= b1_r * b1_r;
      kk2_r  <= k1_r * k1_r;
      wsq2_r <= wm1_r * wm1_r;
    end
  end

  // ---------------- stage 3: sum, range check ----------------
  logic [SW-1:0]   s3;
  logic [RemW-1:0] rem3;
  assign s3   = SW'(aa2_r) + SW'(bb2_r);
  assign rem3 = RemW'(s3) << bmg_pkg::PreShift;

  // ---------------- ratio divider: one quotient bit a stage ----------------
  logic            dv_r   [PowW+1];
  logic            dz_r   [PowW+1];
  logic            dovf_r [PowW+1];
  logic [RemW-1:0] drem_r [PowW+1];
  logic [KKW-1:0]  dkk_r  [PowW+1];
  logic [PowW-1:0] dq_r   [PowW+1];
  logic [RemW-1:0] dsh_nxt [1:PowW];
  logic            dge_nxt [1:PowW];

  always_comb begin
    for (int g = 1; g <= PowW; g++) begin
      dsh_nxt[g] = drem_r[g-1] << 1;
      dge_nxt[g] = dsh_nxt[g] >= {1'b0, dkk_r[g-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g <= PowW; g++) dv_r[g] <= 1'b0;
    end else if (en) begin
      dv_r[0]   <= v2_r;
      dz_r[0]   <= z2_r | kz2_r | (32'(s3) > 32'(wsq2_r));
      dovf_r[0] <= rem3 >= {1'b0, kk2_r};
      drem_r[0] <= rem3;
      dkk_r[0]  <= kk2_r;
      dq_r[0]   <= '0;
      for (int g = 1; g <= PowW; g++) begin
        dv_r[g]   <= dv_r[g-1];
        dz_r[g]   <= dz_r[g-1];
        dovf_r[g] <= dovf_r[g-1];
        dkk_r[g]  <= dkk_r[g-1];
        drem_r[g] <= dge_nxt[g] ? dsh_nxt[g] - {1'b0, dkk_r[g-1]} : dsh_nxt[g];
        dq_r[g]   <= {dq_r[g-1][PowW-2:0], dge_nxt[g]};
      end
    end
  end

  // ---------------- power: one order bit per two stages ----------------
  bmg_pkg::pw_t pw [PSteps+1];

  assign pw[0].v    = dv_r[PowW];
  assign pw[0].z    = dz_r[PowW];
  assign pw[0].ovf  = dovf_r[PowW] & (order_r != '0);
  assign pw[0].acc  = PowW'(1) << bmg_pkg::FracW;
  assign pw[0].base = dq_r[PowW];

  for (genvar i = 0; i < PSteps; i++) begin : g_pow
    bmg_pkg::pw_t   d1_r, d2_r;
    logic [PowW-1:0] pa, pb;
    logic            oa, ob;
    logic            bit_set, more;

    bmg_mulq32 u_acc (.clk(clk), .en(en), .a(pw[i].acc),  .b(pw[i].base), .p(pa), .ovf(oa));
    bmg_mulq32 u_sq  (.clk(clk), .en(en), .a(pw[i].base), .b(pw[i].base), .p(pb), .ovf(ob));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_r <= '0;
        d2_r <= '0;
      end else if (en) begin
        d1_r <= pw[i];
        d2_r <= d1_r;
      end
    end

    assign bit_set = order_r[i];
    assign more    = |(order_r >> (i + 1));

    assign pw[i+1].v    = d2_r.v;
    assign pw[i+1].z    = d2_r.z;
    assign pw[i+1].ovf  = d2_r.ovf | (bit_set & oa) | (more & ob);
    assign pw[i+1].acc  = bit_set ? pa : d2_r.acc;
    assign pw[i+1].base = more ? pb : d2_r.base;
  end

  // ---------------- reciprocal divider ----------------
  logic [DenW-1:0] den0;
  assign den0 = (DenW'(1) << bmg_pkg::FracW) + DenW'(pw[PSteps].acc);

  logic             rv_r   [QW+1];
  logic             rz_r   [QW+1];
  logic [RDivW-1:0] rrem_r [QW+1];
  logic [DenW-1:0]  rden_r [QW+1];
  logic [QW-1:0]    rq_r   [QW+1];
  logic [RDivW-1:0] rsh_nxt [1:QW];
  logic             rge_nxt [1:QW];

  always_comb begin
    for (int g = 1; g <= QW; g++) begin
      rsh_nxt[g] = RDivW'(rden_r[g-1]) << (QW - g);
      rge_nxt[g] = rrem_r[g-1] >= rsh_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g <= QW; g++) rv_r[g] <= 1'b0;
    end else if (en) begin
      rv_r[0]   <= pw[PSteps].v;
      rz_r[0]   <= pw[PSteps].z | pw[PSteps].ovf;
      rden_r[0] <= den0;
      rrem_r[0] <= (RDivW'(1) << 48) + RDivW'(den0 >> 1);
      rq_r[0]   <= '0;
      for (int g = 1; g <= QW; g++) begin
        rv_r[g]   <= rv_r[g-1];
        rz_r[g]   <= rz_r[g-1];
        rden_r[g] <= rden_r[g-1];
        rrem_r[g] <= rge_nxt[g] ? rrem_r[g-1] - rsh_nxt[g] : rrem_r[g-1];
        rq_r[g]   <= {rq_r[g-1][QW-2:0], rge_nxt[g]};
      end
    end
  end

  logic [QW-1:0] fin_resp;
  assign fin_resp = rz_r[QW] ? '0 : rq_r[QW];

  // ---------------- output register with skid ----------------
  logic [QW-1:0] out_d_r, skid_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (en && rv_r[QW]) begin
        if (!out_v_r || out_tready) begin
          out_v_r <= 1'b1;
          out_d_r <= fin_resp;
        end else begin
          skid_v_r <= 1'b1;
          skid_d_r <= fin_resp;
        end
      end else if (skid_v_r && out_tready) begin
        // drain the held item into the output register
        out_v_r  <= 1'b1;
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_d_r};

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds an item while output is empty");

  a_resp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_d_r <= 17'h10000)) else $error("response above unity");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_tready) |=> (skid_v_r && $stable(skid_d_r)))
    else $error("held item lost during stall");

endmodule

// File: src/bmg_mulq32.sv
module bmg_mulq32 (
  input  logic                      clk,
  input  logic                      en,
  input  logic [bmg_pkg::PowW-1:0]  a,
  input  logic [bmg_pkg::PowW-1:0]  b,
  output logic [bmg_pkg::PowW-1:0]  p,
  output logic                      ovf
);

  localparam int HW  = bmg_pkg::PowW - bmg_pkg::FracW;
  localparam int FW  = bmg_pkg::FracW;
  localparam int SumW = bmg_pkg::PpW + FW + 1;

  logic [bmg_pkg::PpW-1:0] hh_r;
  logic [HW+FW-1:0]        hl_r;
  logic [HW+FW-1:0]        lh_r;
  logic [2*FW-1:0]         ll_r;
  logic [SumW-1:0]         sum_nxt;
  logic [bmg_pkg::PowW-1:0] p_r;
  logic                     ovf_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= a[bmg_pkg::PowW-1:FW] * b[bmg_pkg::PowW-1:FW];
      hl_r <= a[bmg_pkg::PowW-1:FW] * b[FW-1:0];
      lh_r <= a[FW-1:0] * b[bmg_pkg::PowW-1:FW];
      ll_r <= a[FW-1:0] * b[FW-1:0];
    end
  end

  assign sum_nxt = {1'b0, hh_r, {FW{1'b0}}} + SumW'(hl_r) + SumW'(lh_r)
                 + SumW'(ll_r[2*FW-1:FW]);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= sum_nxt[bmg_pkg::PowW-1:0];
      ovf_r <= |sum_nxt[SumW-1:bmg_pkg::PowW];
    end
  end

  assign p   = p_r;
  assign ovf = ovf_r;

endmodule
